### hdl/hvwt_pkg.sv
// Package for the haptic virtual-world torque block: widths, codes, state
// encodings and the control structs shared by the sequencer and its units.
// No dependencies.
`timescale 1ns / 1ps

package hvwt_pkg;

	// value range of the saturated torque and of the virtual mass state
	localparam int VALUE_WIDTH = 32;

	// field and register widths
	localparam int IN_W       = 32;
	localparam int OUT_W      = 32;
	localparam int MODE_W     = 2;
	localparam int GAIN_W     = 31;
	localparam int STEP_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int FRAC_W     = 16;

	// product magnitude, signed product and sum widths
	localparam int BASE_W = (VALUE_WIDTH > IN_W) ? VALUE_WIDTH : IN_W;
	localparam int MAG_W  = BASE_W + 18;
	localparam int PROD_W = MAG_W + 1;
	localparam int SUM_W  = MAG_W + 2;

	// serial multiplier: one multiplier bit per cycle
	localparam int MUL_STEPS = STEP_W;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);

	// serial remainder unit: one dividend bit per cycle
	localparam int DIV_N_W   = IN_W + 1;
	localparam int DIV_D_W   = GAIN_W + 1;
	localparam int DIV_CNT_W = $clog2(DIV_N_W);
	localparam int RES_W     = IN_W + 2;

	// register reset values
	localparam logic [GAIN_W-1:0] SPRING_RST  = GAIN_W'(3276800);
	localparam logic [GAIN_W-1:0] DAMPING_RST = GAIN_W'(81920);
	localparam logic [STEP_W-1:0] STEP_RST    = STEP_W'(4294967);
	localparam logic [GAIN_W-1:0] INV_J_RST   = GAIN_W'(145635);
	localparam logic [GAIN_W-1:0] DETENT_RST  = GAIN_W'(1310720);

	typedef enum logic [MODE_W-1:0] {
		MODE_SPRING = 2'd0,
		MODE_WALL   = 2'd1,
		MODE_SMD    = 2'd2,
		MODE_KNOB   = 2'd3
	} world_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE    = 3'd0,
		CFG_SPRING  = 3'd1,
		CFG_DAMPING = 3'd2,
		CFG_STEP    = 3'd3,
		CFG_INV_J   = 3'd4,
		CFG_DETENT  = 3'd5
	} cfg_index_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'd0,
		S_DIV  = 3'd1,
		S_P1   = 3'd2,
		S_P2   = 3'd3,
		S_P3   = 3'd4,
		S_P4   = 3'd5,
		S_P5   = 3'd6,
		S_FIN  = 3'd7
	} seq_state_t;

	typedef struct packed {
		logic start;
		logic shr32;
	} mul_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_rsp_t;

endpackage

### hdl/hvwt_if.sv
// Handshake channels of the haptic torque block: sample in, torque out,
// and the register write port. Depends on hvwt_pkg.
`timescale 1ns / 1ps

interface hvwt_sample_if;
	logic                              valid;
	logic                              ready;
	logic signed [hvwt_pkg::IN_W-1:0] wheel_angle;
	logic signed [hvwt_pkg::IN_W-1:0] wheel_velocity;

	modport source (output valid, output wheel_angle, output wheel_velocity, input ready);
	modport sink   (input valid, input wheel_angle, input wheel_velocity, output ready);
endinterface

interface hvwt_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [hvwt_pkg::OUT_W-1:0] torque;

	modport source (output valid, output torque, input ready);
	modport sink   (input valid, input torque, output ready);
endinterface

interface hvwt_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [hvwt_pkg::CFG_IDX_W-1:0]    index;
	logic [hvwt_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/hvwt_serial_mul.sv
// Bit-serial signed-by-unsigned multiplier with a fixed-point shift back
// (16 or 32 bits), truncating toward zero. Depends on hvwt_pkg.
`timescale 1ns / 1ps

module hvwt_serial_mul (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  hvwt_pkg::mul_req_t                    req,
	input  logic signed [hvwt_pkg::PROD_W-1:0]   a,
	input  logic [hvwt_pkg::STEP_W-1:0]          b,
	output hvwt_pkg::unit_rsp_t                   rsp,
	output logic signed [hvwt_pkg::PROD_W-1:0]   product
);

	localparam int HI_W = hvwt_pkg::STEP_W - hvwt_pkg::FRAC_W;

	logic                                busy_q;
	logic                                done_q;
	logic [hvwt_pkg::MUL_CNT_W-1:0]     cnt_q;
	logic                                neg_q;
	logic                                shr32_q;
	logic [hvwt_pkg::MAG_W-1:0]         a_q;
	logic [hvwt_pkg::STEP_W-1:0]        b_q;
	logic [hvwt_pkg::MAG_W-1:0]         acc_q;
	logic [hvwt_pkg::STEP_W-1:0]        lo_q;

	logic [hvwt_pkg::PROD_W-1:0]        a_abs;
	logic [hvwt_pkg::MAG_W:0]           addend;
	logic [hvwt_pkg::MAG_W:0]           sum;
	logic [hvwt_pkg::MAG_W+HI_W-1:0]   wide16;
	logic [hvwt_pkg::MAG_W-1:0]         mag;
	logic signed [hvwt_pkg::PROD_W-1:0] mag_ext;

	// operand magnitude and one partial product per cycle
	always_comb begin
		a_abs  = a[hvwt_pkg::PROD_W-1] ? hvwt_pkg::PROD_W'(-a) : a;
		addend = b_q[0] ? {1'b0, a_q} : '0;
		sum    = {1'b0, acc_q} + addend;
	end

	// sequencing: a start beat, the shift-add steps, then a done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == hvwt_pkg::MUL_CNT_W'(hvwt_pkg::MUL_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath: multiplier bits leave LSB first, product low bits shift in
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q     <= a_abs[hvwt_pkg::MAG_W-1:0];
			b_q     <= b;
			acc_q   <= '0;
			lo_q    <= '0;
			neg_q   <= a[hvwt_pkg::PROD_W-1];
			shr32_q <= req.shr32;
		end else if (busy_q) begin
			acc_q <= sum[hvwt_pkg::MAG_W:1];
			lo_q  <= {sum[0], lo_q[hvwt_pkg::STEP_W-1:1]};
			b_q   <= b_q >> 1;
		end
	end

	// shift back, clamp an oversize magnitude in the 16-bit shift, restore the sign
	always_comb begin
		wide16 = {acc_q, lo_q[hvwt_pkg::STEP_W-1:hvwt_pkg::FRAC_W]};
		if (shr32_q) begin
			mag = acc_q;
		end else if (wide16[hvwt_pkg::MAG_W+HI_W-1:hvwt_pkg::MAG_W] != '0) begin
			mag = '1;
		end else begin
			mag = wide16[hvwt_pkg::MAG_W-1:0];
		end
		mag_ext = {1'b0, mag};
		product = neg_q ? -mag_ext : mag_ext;
	end

	assign rsp = '{busy: busy_q, done: done_q};

endmodule

### hdl/hvwt_serial_div.sv
// Bit-serial restoring remainder unit for the detent rounding: unsigned
// dividend and divisor, remainder only. Depends on hvwt_pkg.
`timescale 1ns / 1ps

module hvwt_serial_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [hvwt_pkg::DIV_N_W-1:0]   num,
	input  logic [hvwt_pkg::DIV_D_W-1:0]   den,
	output hvwt_pkg::unit_rsp_t             rsp,
	output logic [hvwt_pkg::DIV_D_W-1:0]   rem
);

	logic                             busy_q;
	logic                             done_q;
	logic [hvwt_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [hvwt_pkg::DIV_N_W-1:0]    num_q;
	logic [hvwt_pkg::DIV_D_W-1:0]    den_q;
	logic [hvwt_pkg::DIV_D_W-1:0]    rem_q;

	logic [hvwt_pkg::DIV_D_W:0]      trial;
	logic [hvwt_pkg::DIV_D_W:0]      diff;
	logic                             fits;

	// one trial subtraction per dividend bit
	always_comb begin
		trial = {rem_q, num_q[hvwt_pkg::DIV_N_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = (trial >= {1'b0, den_q});
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == hvwt_pkg::DIV_CNT_W'(hvwt_pkg::DIV_N_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// dividend shifts out MSB first into the partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= fits ? diff[hvwt_pkg::DIV_D_W-1:0] : trial[hvwt_pkg::DIV_D_W-1:0];
		end
	end

	assign rem = rem_q;
	assign rsp = '{busy: busy_q, done: done_q};

endmodule

### hdl/haptic_virtual_world_torque.sv
// Top level of the haptic virtual-world torque block: registers, sequencer,
// virtual mass state and output register. Depends on hvwt_pkg, hvwt_if,
// hvwt_serial_mul and hvwt_serial_div.
`timescale 1ns / 1ps

// Each sample beat (wheel angle and velocity, signed Q16.16) yields one torque
// beat, signed Q16.16, saturated. All products go one at a time through a
// shared bit-serial multiplier that takes one multiplier bit per cycle; a
// product is a start beat, the shift-add steps and a done pulse. The detent
// knob adds one bit-serial remainder pass when the detent width is nonzero.
// Spring-damper, wall and knob modes run two products, spring-mass-damper
// mode five. The input is taken only while the sequencer is idle; a
// finished torque waits in the output register, and the sequencer holds in
// its last step only if that register is still occupied. Register writes
// are accepted in every cycle and belong between samples. The virtual mass
// state resets to zero.
module haptic_virtual_world_torque (
	input  logic                 clk,
	input  logic                 arst_n,
	hvwt_sample_if.sink          sample,
	hvwt_result_if.source        result,
	hvwt_cfg_if.sink             cfg
);

	// saturate a wide signed sum to the value range
	function automatic logic signed [hvwt_pkg::VALUE_WIDTH-1:0] sat_value(
		input logic signed [hvwt_pkg::SUM_W-1:0] x
	);
		logic signed [hvwt_pkg::SUM_W-1:0]       hi;
		logic signed [hvwt_pkg::SUM_W-1:0]       lo;
		logic signed [hvwt_pkg::VALUE_WIDTH-1:0] r;
		hi = hvwt_pkg::SUM_W'(signed'({1'b0, {(hvwt_pkg::VALUE_WIDTH-1){1'b1}}}));
		lo = ~hi;
		if (x > hi) begin
			r = hi[hvwt_pkg::VALUE_WIDTH-1:0];
		end else if (x < lo) begin
			r = lo[hvwt_pkg::VALUE_WIDTH-1:0];
		end else begin
			r = x[hvwt_pkg::VALUE_WIDTH-1:0];
		end
		return r;
	endfunction

	// registers
	hvwt_pkg::world_mode_t             mode_q;
	logic [hvwt_pkg::GAIN_W-1:0]      spring_q;
	logic [hvwt_pkg::GAIN_W-1:0]      damping_q;
	logic [hvwt_pkg::STEP_W-1:0]      step_q;
	logic [hvwt_pkg::GAIN_W-1:0]      inv_j_q;
	logic [hvwt_pkg::GAIN_W-1:0]      detent_q;

	// sequencer and working values
	hvwt_pkg::seq_state_t                  state_q;
	hvwt_pkg::seq_state_t                  state_d;
	logic signed [hvwt_pkg::IN_W-1:0]        angle_q;
	logic signed [hvwt_pkg::IN_W-1:0]        vel_q;
	logic signed [hvwt_pkg::VALUE_WIDTH-1:0] x1_q;
	logic signed [hvwt_pkg::VALUE_WIDTH-1:0] x2_q;
	logic signed [hvwt_pkg::RES_W-1:0]       res_q;
	logic signed [hvwt_pkg::PROD_W-1:0]      p1_q;
	logic signed [hvwt_pkg::PROD_W-1:0]      p2_q;
	logic signed [hvwt_pkg::PROD_W-1:0]      p3_q;
	logic signed [hvwt_pkg::PROD_W-1:0]      p4_q;
	logic signed [hvwt_pkg::PROD_W-1:0]      p5_q;
	logic                                    out_valid_q;
	logic signed [hvwt_pkg::OUT_W-1:0]       torque_q;

	// unit handshakes and operands
	hvwt_pkg::mul_req_t                    mul_req;
	hvwt_pkg::unit_rsp_t                   mul_rsp;
	hvwt_pkg::unit_rsp_t                   div_rsp;
	logic signed [hvwt_pkg::PROD_W-1:0]    mul_a;
	logic [hvwt_pkg::STEP_W-1:0]          mul_b;
	logic signed [hvwt_pkg::PROD_W-1:0]    mul_p;
	logic                                  div_start;
	logic [hvwt_pkg::DIV_N_W-1:0]         div_num;
	logic [hvwt_pkg::DIV_D_W-1:0]         div_den;
	logic [hvwt_pkg::DIV_D_W-1:0]         div_rem;

	// load enables from the sequencer
	logic in_ready;
	logic ld_res;
	logic ld_p1;
	logic ld_p2;
	logic ld_p3;
	logic ld_p4;
	logic ld_p5;
	logic out_load;
	logic mass_upd;

	// derived values
	logic [hvwt_pkg::RES_W-1:0]               n_full;
	logic                                     n_neg;
	logic [hvwt_pkg::RES_W-1:0]               n_abs;
	logic signed [hvwt_pkg::DIV_N_W-1:0]      rem_signed;
	logic signed [hvwt_pkg::RES_W-1:0]        res_diff;
	logic signed [hvwt_pkg::RES_W-1:0]        res_next;
	logic signed [hvwt_pkg::PROD_W-1:0]       pos_err;
	logic signed [hvwt_pkg::PROD_W-1:0]       vel_err;
	logic signed [hvwt_pkg::PROD_W-1:0]       knob_err;
	logic signed [hvwt_pkg::SUM_W-1:0]        f_sum;
	logic signed [hvwt_pkg::SUM_W-1:0]        neg_sum;
	logic signed [hvwt_pkg::SUM_W-1:0]        x1_sum;
	logic signed [hvwt_pkg::SUM_W-1:0]        x2_sum;
	logic signed [hvwt_pkg::VALUE_WIDTH-1:0]  torque_sat;
	logic                                     knob_div;

	// register writes, masked to each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= hvwt_pkg::MODE_SPRING;
			spring_q  <= hvwt_pkg::SPRING_RST;
			damping_q <= hvwt_pkg::DAMPING_RST;
			step_q    <= hvwt_pkg::STEP_RST;
			inv_j_q   <= hvwt_pkg::INV_J_RST;
			detent_q  <= hvwt_pkg::DETENT_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				hvwt_pkg::CFG_MODE: begin
					mode_q <= hvwt_pkg::world_mode_t'(cfg.data[hvwt_pkg::MODE_W-1:0]);
				end
				hvwt_pkg::CFG_SPRING:  spring_q  <= cfg.data[hvwt_pkg::GAIN_W-1:0];
				hvwt_pkg::CFG_DAMPING: damping_q <= cfg.data[hvwt_pkg::GAIN_W-1:0];
				hvwt_pkg::CFG_STEP:    step_q    <= cfg.data[hvwt_pkg::STEP_W-1:0];
				hvwt_pkg::CFG_INV_J:   inv_j_q   <= cfg.data[hvwt_pkg::GAIN_W-1:0];
				hvwt_pkg::CFG_DETENT:  detent_q  <= cfg.data[hvwt_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	// detent rounding: n = trunc((2a + w) / 2w), so a - n*w = (r - w) / 2
	always_comb begin
		n_full     = {angle_q[hvwt_pkg::IN_W-1], angle_q, 1'b0}
		           + {{(hvwt_pkg::RES_W-hvwt_pkg::GAIN_W){1'b0}}, detent_q};
		n_neg      = n_full[hvwt_pkg::RES_W-1];
		n_abs      = n_neg ? -n_full : n_full;
		div_num    = n_abs[hvwt_pkg::DIV_N_W-1:0];
		div_den    = {detent_q, 1'b0};
		rem_signed = n_neg ? -signed'({1'b0, div_rem}) : signed'({1'b0, div_rem});
		res_diff   = hvwt_pkg::RES_W'(rem_signed)
		           - hvwt_pkg::RES_W'(signed'({1'b0, detent_q}));
		res_next   = res_diff >>> 1;
		knob_div   = (mode_q == hvwt_pkg::MODE_KNOB) && (detent_q != '0);
	end

	// multiplier operands and the sums that follow the products
	always_comb begin
		pos_err  = hvwt_pkg::PROD_W'(angle_q) - hvwt_pkg::PROD_W'(x1_q);
		vel_err  = hvwt_pkg::PROD_W'(vel_q) - hvwt_pkg::PROD_W'(x2_q);
		knob_err = (detent_q == '0) ? hvwt_pkg::PROD_W'(angle_q) : hvwt_pkg::PROD_W'(res_q);
		f_sum    = hvwt_pkg::SUM_W'(p1_q) + hvwt_pkg::SUM_W'(p2_q);
		neg_sum  = -hvwt_pkg::SUM_W'(p1_q) - hvwt_pkg::SUM_W'(p2_q);
		x1_sum   = hvwt_pkg::SUM_W'(x1_q) + hvwt_pkg::SUM_W'(p4_q);
		x2_sum   = hvwt_pkg::SUM_W'(x2_q) + hvwt_pkg::SUM_W'(p5_q);
		case (mode_q)
			hvwt_pkg::MODE_SMD:  torque_sat = sat_value(f_sum);
			hvwt_pkg::MODE_WALL: torque_sat = (angle_q > 0) ? '0 : sat_value(neg_sum);
			default:             torque_sat = sat_value(neg_sum);
		endcase
	end

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hvwt_pkg::S_IDLE: begin
				if (sample.valid) begin
					state_d = knob_div ? hvwt_pkg::S_DIV : hvwt_pkg::S_P1;
				end
			end
			hvwt_pkg::S_DIV: if (div_rsp.done) state_d = hvwt_pkg::S_P1;
			hvwt_pkg::S_P1:  if (mul_rsp.done) state_d = hvwt_pkg::S_P2;
			hvwt_pkg::S_P2: begin
				if (mul_rsp.done) begin
					state_d = (mode_q == hvwt_pkg::MODE_SMD) ? hvwt_pkg::S_P3 : hvwt_pkg::S_FIN;
				end
			end
			hvwt_pkg::S_P3:  if (mul_rsp.done) state_d = hvwt_pkg::S_P4;
			hvwt_pkg::S_P4:  if (mul_rsp.done) state_d = hvwt_pkg::S_P5;
			hvwt_pkg::S_P5:  if (mul_rsp.done) state_d = hvwt_pkg::S_FIN;
			hvwt_pkg::S_FIN: if (!out_valid_q || result.ready) state_d = hvwt_pkg::S_IDLE;
			default:         state_d = hvwt_pkg::S_IDLE;
		endcase
	end

	// sequencer: outputs (unit starts, operand select, load enables)
	always_comb begin
		in_ready      = 1'b0;
		div_start     = 1'b0;
		mul_req.start = 1'b0;
		mul_req.shr32 = 1'b0;
		mul_a         = pos_err;
		mul_b         = {{(hvwt_pkg::STEP_W-hvwt_pkg::GAIN_W){1'b0}}, spring_q};
		ld_res        = 1'b0;
		ld_p1         = 1'b0;
		ld_p2         = 1'b0;
		ld_p3         = 1'b0;
		ld_p4         = 1'b0;
		ld_p5         = 1'b0;
		out_load      = 1'b0;
		mass_upd      = 1'b0;
		case (state_q)
			hvwt_pkg::S_IDLE: in_ready = 1'b1;
			hvwt_pkg::S_DIV: begin
				div_start = !div_rsp.busy && !div_rsp.done;
				ld_res    = div_rsp.done;
			end
			hvwt_pkg::S_P1: begin
				mul_req.start = !mul_rsp.busy && !mul_rsp.done;
				case (mode_q)
					hvwt_pkg::MODE_SMD:  mul_a = pos_err;
					hvwt_pkg::MODE_KNOB: mul_a = knob_err;
					default:             mul_a = hvwt_pkg::PROD_W'(angle_q);
				endcase
				ld_p1 = mul_rsp.done;
			end
			hvwt_pkg::S_P2: begin
				mul_req.start = !mul_rsp.busy && !mul_rsp.done;
				mul_a = (mode_q == hvwt_pkg::MODE_SMD) ? vel_err : hvwt_pkg::PROD_W'(vel_q);
				mul_b = {{(hvwt_pkg::STEP_W-hvwt_pkg::GAIN_W){1'b0}}, damping_q};
				ld_p2 = mul_rsp.done;
			end
			hvwt_pkg::S_P3: begin
				// impulse dt*F
				mul_req.start = !mul_rsp.busy && !mul_rsp.done;
				mul_req.shr32 = 1'b1;
				mul_a = hvwt_pkg::PROD_W'(f_sum);
				mul_b = step_q;
				ld_p3 = mul_rsp.done;
			end
			hvwt_pkg::S_P4: begin
				// position step dt*x2 with the old velocity
				mul_req.start = !mul_rsp.busy && !mul_rsp.done;
				mul_req.shr32 = 1'b1;
				mul_a = hvwt_pkg::PROD_W'(x2_q);
				mul_b = step_q;
				ld_p4 = mul_rsp.done;
			end
			hvwt_pkg::S_P5: begin
				// velocity step impulse/J
				mul_req.start = !mul_rsp.busy && !mul_rsp.done;
				mul_a = p3_q;
				mul_b = {{(hvwt_pkg::STEP_W-hvwt_pkg::GAIN_W){1'b0}}, inv_j_q};
				ld_p5 = mul_rsp.done;
			end
			hvwt_pkg::S_FIN: begin
				out_load = !out_valid_q || result.ready;
				mass_upd = out_load && (mode_q == hvwt_pkg::MODE_SMD);
			end
			default: ;
		endcase
	end

	assign sample.ready = in_ready;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hvwt_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			x1_q        <= '0;
			x2_q        <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (mass_upd) begin
				x1_q <= sat_value(x1_sum);
				x2_q <= sat_value(x2_sum);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (sample.valid && in_ready) begin
			angle_q <= sample.wheel_angle;
			vel_q   <= sample.wheel_velocity;
		end
		if (ld_res)   res_q    <= res_next;
		if (ld_p1)    p1_q     <= mul_p;
		if (ld_p2)    p2_q     <= mul_p;
		if (ld_p3)    p3_q     <= mul_p;
		if (ld_p4)    p4_q     <= mul_p;
		if (ld_p5)    p5_q     <= mul_p;
		if (out_load) torque_q <= hvwt_pkg::OUT_W'(torque_sat);
	end

	assign result.valid  = out_valid_q;
	assign result.torque = torque_q;

	hvwt_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.a       (mul_a),
		.b       (mul_b),
		.rsp     (mul_rsp),
		.product (mul_p)
	);

	hvwt_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.rsp    (div_rsp),
		.rem    (div_rem)
	);

`ifndef SYNTHESIS
	// the multiplier and the divider never run at the same time
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_rsp.busy && div_rsp.busy))
		else $error("multiplier and divider busy together");

	// a product finishes only in a product step
	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == hvwt_pkg::S_P1 || state_q == hvwt_pkg::S_P2 ||
		                  state_q == hvwt_pkg::S_P3 || state_q == hvwt_pkg::S_P4 ||
		                  state_q == hvwt_pkg::S_P5))
		else $error("product finished outside a product step");

	// a remainder finishes only in the rounding step
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == hvwt_pkg::S_DIV)
		else $error("remainder finished outside the rounding step");

	// the virtual mass moves only after a spring-mass-damper sample
	a_mass_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(!$stable(x1_q) || !$stable(x2_q)) |->
		($past(mode_q) == hvwt_pkg::MODE_SMD && $past(state_q) == hvwt_pkg::S_FIN))
		else $error("mass state changed outside a spring-mass-damper update");

	// a torque beat appears only from the final step
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == hvwt_pkg::S_FIN)
		else $error("torque beat raised outside the final step");
`endif

endmodule
